FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and idle during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// types and character constants of the fixed-point decimal formatter
// ----------------------------------------------------------------------------
`default_nettype none

package fpdf_pkg;

	typedef struct packed {
		logic       neg;
		logic [1:0] mode;
		logic       cur;
		logic [3:0] lim;
	} ctrl_t;

	localparam logic [1:0] MODE_ZERO    = 2'd0;
	localparam logic [1:0] MODE_ONE     = 2'd1;
	localparam logic [1:0] MODE_TWO     = 2'd2;
	localparam logic [1:0] MODE_GENERAL = 2'd3;

	localparam logic [6:0] ROUND_WHOLE = 7'd50;
	localparam logic [6:0] ROUND_TENTH = 7'd5;

	localparam logic [3:0] MAX_CHARS = 4'd13;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [3:0] CH_DIGIT_HI = 4'h3;

endpackage

`default_nettype wire

FILE: rtl/core/fpdf_front.sv
// ----------------------------------------------------------------------------
// fpdf_front
// takes a command, forms magnitude with rounding offset and character limit
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [VALUE_WIDTH-1:0]  value,
	input  wire logic [1:0]              decimals_mode,
	input  wire logic                    currency,
	input  wire logic [7:0]              buffer_len,
	input  wire logic                    q_full,
	output logic                         push,
	output fpdf_pkg::ctrl_t              ctrl,
	output logic [VALUE_WIDTH-1:0]       adj
);
	import fpdf_pkg::*;

	logic                   valid_s1;
	ctrl_t                  ctrl_s1;
	logic [VALUE_WIDTH-1:0] adj_s1;
	logic                   take;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic [6:0]             rnd;
	logic [7:0]             lim8;
	ctrl_t                  ctrl_nx;

	assign busy = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;
	assign take = start && !busy;

	always_comb begin
		neg = value[VALUE_WIDTH-1];
		mag = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
		if (currency) begin
			rnd = 7'd0;
		end else begin
			unique case (decimals_mode)
				MODE_ZERO: rnd = ROUND_WHOLE;
				MODE_ONE:  rnd = ROUND_TENTH;
				default:   rnd = 7'd0;
			endcase
		end
		lim8 = (buffer_len == 8'd0) ? 8'd0 : buffer_len - 8'd1;
		ctrl_nx.neg  = neg;
		ctrl_nx.mode = decimals_mode;
		ctrl_nx.cur  = currency;
		ctrl_nx.lim  = (lim8 > {4'd0, MAX_CHARS}) ? MAX_CHARS : lim8[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl_nx;
			adj_s1  <= mag + {{(VALUE_WIDTH-7){1'b0}}, rnd};
		end
	end

	assign ctrl = ctrl_s1;
	assign adj  = adj_s1;

endmodule

`default_nettype wire

FILE: rtl/core/fpdf_queue.sv
// ----------------------------------------------------------------------------
// fpdf_queue
// two-entry queue between the command front and the character back
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_queue #(
	parameter int WIDTH = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fpdf_back.sv
// ----------------------------------------------------------------------------
// fpdf_back
// binary to bcd conversion, two bits a cycle, then at most one character a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fpdf_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    empty,
	input  wire fpdf_pkg::ctrl_t         ctrl,
	input  wire logic [VALUE_WIDTH-1:0]  adj,
	output logic                         pop,
	output logic                         strobe,
	output logic [7:0]                   char_code,
	output logic                         final_res
);
	import fpdf_pkg::*;

	localparam int PW = VALUE_WIDTH + (VALUE_WIDTH % 2);
	localparam int ND = (VALUE_WIDTH * 30103) / 100000 + 2;
	localparam int BW = ND * 4 + PW;
	localparam int STEPS = PW / 2;
	localparam int SCW = $clog2(STEPS + 1);
	localparam int WCW = $clog2(ND);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CONV  = 4'd1;
	localparam logic [3:0] ST_SIGN  = 4'd2;
	localparam logic [3:0] ST_CUR   = 4'd3;
	localparam logic [3:0] ST_WHOLE = 4'd4;
	localparam logic [3:0] ST_DOT   = 4'd5;
	localparam logic [3:0] ST_FRAC1 = 4'd6;
	localparam logic [3:0] ST_FRAC2 = 4'd7;
	localparam logic [3:0] ST_END   = 4'd8;

	logic [3:0]      state_q;
	ctrl_t           ctrl_q;
	logic [PW-1:0]   bin_q;
	logic [ND*4-1:0] bcd_q;
	logic [SCW-1:0]  step_q;
	logic [WCW-1:0]  wc_q;
	logic [3:0]      cnt_q;
	logic [1:0]      places_q;
	logic            started_q;
	logic            strobe_q;
	logic [7:0]      char_q;
	logic            final_q;

	logic [BW-1:0]   dd;
	logic [1:0]      places_nx;
	logic [3:0]      top_dig;
	logic            want;
	logic [7:0]      ch;
	logic            emitting;
	logic            cut;

	assign pop = (state_q == ST_IDLE) && !empty;
	assign top_dig = bcd_q[ND*4-1 -: 4];

	// two shift-add-3 steps
	always_comb begin
		dd = {bcd_q, bin_q};
		for (int s = 0; s < 2; s++) begin
			for (int d = 0; d < ND; d++) begin
				if (dd[PW + 4*d +: 4] >= 4'd5) begin
					dd[PW + 4*d +: 4] = dd[PW + 4*d +: 4] + 4'd3;
				end
			end
			dd = dd << 1;
		end
	end

	// places from the last two bcd digits of the finished conversion
	always_comb begin
		if (ctrl_q.cur) begin
			places_nx = MODE_TWO;
		end else if (ctrl_q.mode == MODE_GENERAL) begin
			if (dd[PW +: 8] == 8'd0) begin
				places_nx = MODE_ZERO;
			end else if (dd[PW +: 4] == 4'd0) begin
				places_nx = MODE_ONE;
			end else begin
				places_nx = MODE_TWO;
			end
		end else begin
			places_nx = ctrl_q.mode;
		end
	end

	always_comb begin
		want     = 1'b0;
		ch       = CH_NUL;
		emitting = 1'b1;
		unique case (state_q)
			ST_SIGN: begin
				want = ctrl_q.neg;
				ch   = CH_MINUS;
			end
			ST_CUR: begin
				want = ctrl_q.cur;
				ch   = CH_DOLLAR;
			end
			ST_WHOLE: begin
				want = started_q || (top_dig != 4'd0) || (wc_q == WCW'(1));
				ch   = {CH_DIGIT_HI, top_dig};
			end
			ST_DOT: begin
				want = (places_q != MODE_ZERO);
				ch   = CH_DOT;
			end
			ST_FRAC1: begin
				want = (places_q != MODE_ZERO);
				ch   = {CH_DIGIT_HI, top_dig};
			end
			ST_FRAC2: begin
				want = (places_q == MODE_TWO);
				ch   = {CH_DIGIT_HI, top_dig};
			end
			default: begin
				emitting = 1'b0;
			end
		endcase
		cut = emitting && want && (cnt_q == ctrl_q.lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			strobe_q <= cut || (emitting && want) || (state_q == ST_END);
			final_q  <= cut || (state_q == ST_END);
			if (cut) begin
				state_q <= ST_IDLE;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (!empty) begin
							state_q <= ST_CONV;
						end
					end
					ST_CONV: begin
						if (step_q == SCW'(1)) begin
							state_q <= ST_SIGN;
						end
					end
					ST_SIGN:  state_q <= ST_CUR;
					ST_CUR:   state_q <= ST_WHOLE;
					ST_WHOLE: begin
						if (wc_q == WCW'(1)) begin
							state_q <= ST_DOT;
						end
					end
					ST_DOT:   state_q <= ST_FRAC1;
					ST_FRAC1: state_q <= ST_FRAC2;
					ST_FRAC2: state_q <= ST_END;
					ST_END:   state_q <= ST_IDLE;
					default:  state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q <= cut ? CH_NUL : ch;
		if (emitting && want) begin
			cnt_q <= cnt_q + 4'd1;
		end
		unique case (state_q)
			ST_IDLE: begin
				ctrl_q    <= ctrl;
				bin_q     <= PW'(adj);
				bcd_q     <= '0;
				step_q    <= SCW'(STEPS);
				cnt_q     <= 4'd0;
				started_q <= 1'b0;
				wc_q      <= WCW'(ND - 2);
			end
			ST_CONV: begin
				{bcd_q, bin_q} <= dd;
				step_q         <= step_q - SCW'(1);
				places_q       <= places_nx;
			end
			ST_WHOLE: begin
				bcd_q     <= bcd_q << 4;
				started_q <= started_q || want;
				wc_q      <= wc_q - WCW'(1);
			end
			ST_FRAC1: begin
				bcd_q <= bcd_q << 4;
			end
			default: begin
			end
		endcase
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign final_res = final_q;

endmodule

`default_nettype wire

FILE: rtl/core/fixed_point_decimal_formatter.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// signed hundredths to ascii text, one character per strobe, nul terminated
// ----------------------------------------------------------------------------
// path: a command is registered in the front end and passes through the two-entry queue
// into the back end, which runs binary to bcd conversion, then fixed slots for sign,
// currency, whole digits, dot, two fraction digits and nul; the back end takes the next
// item from the queue only when idle, so the front end and the queue hold later commands;
// VALUE_WIDTH 32 gives 9 whole digit slots; a short buffer ends the item early
// reset clears the queue and the sequencer; the receiver cannot stall
`default_nettype none

module fixed_point_decimal_formatter #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [VALUE_WIDTH-1:0]  value,
	input  wire logic [1:0]              decimals_mode,
	input  wire logic                    currency,
	input  wire logic [7:0]              buffer_len,
	output logic                         strobe,
	output logic [7:0]                   char_code,
	output logic                         final_res
);
	import fpdf_pkg::*;

	`include "assert_macros.svh"

	localparam int QW = $bits(ctrl_t) + VALUE_WIDTH;

	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	ctrl_t                  f_ctrl;
	logic [VALUE_WIDTH-1:0] f_adj;
	logic [QW-1:0]          q_rd;
	ctrl_t                  b_ctrl;
	logic [VALUE_WIDTH-1:0] b_adj;

	fpdf_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.decimals_mode(decimals_mode),
		.currency     (currency),
		.buffer_len   (buffer_len),
		.q_full       (q_full),
		.push         (push),
		.ctrl         (f_ctrl),
		.adj          (f_adj)
	);

	fpdf_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({f_ctrl, f_adj}),
		.pop    (pop),
		.rd_data(q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_ctrl, b_adj} = q_rd;

	fpdf_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.ctrl     (b_ctrl),
		.adj      (b_adj),
		.pop      (pop),
		.strobe   (strobe),
		.char_code(char_code),
		.final_res(final_res)
	);

	`ASSERT_IMPL(a_final_has_strobe, final_res, strobe, "final_res without strobe")
	`ASSERT_IMPL(a_nul_is_final, strobe && final_res, char_code == CH_NUL, "final not nul")
	`ASSERT_IMPL(a_char_not_nul, strobe && !final_res, char_code != CH_NUL, "nul not final")
	`ASSERT_NEXT(a_final_single, final_res, !final_res, "back to back terminators")

endmodule

`default_nettype wire
